// ===== src/mtk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_pkg
// Shared types, constants and the multi-tap character ROM for the keypad
// text entry block.
// ----------------------------------------------------------------------------
package mtk_pkg;

    // Text geometry
    localparam int ROW_LEN   = 16;
    localparam int ROW_COUNT = 10;
    localparam int TEXT_CAP  = ROW_LEN * ROW_COUNT;
    localparam int ADDR_W    = $clog2(TEXT_CAP);
    localparam int LEN_W     = 8;

    localparam logic [15:0] WR_TIMEOUT_RESET = 16'd30000;
    localparam logic [6:0]  SPACE_CHAR       = 7'h20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Raw keypad sample codes
    localparam logic [4:0] KEY_NONE    = 5'd0;
    localparam logic [4:0] KEY_DIGIT0  = 5'd1;
    localparam logic [4:0] KEY_DIGIT9  = 5'd10;
    localparam logic [4:0] KEY_STAR    = 5'd11;
    localparam logic [4:0] KEY_HASH    = 5'd12;
    localparam logic [4:0] KEY_A       = 5'd13;
    localparam logic [4:0] KEY_D       = 5'd16;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DIGIT,
        CMD_STAR,
        CMD_HASH,
        CMD_ANIM
    } cmd_kind_t;

    // Classified key word passed from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] arg;   // digit 0-9, or animation index in [1:0]
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_APPEND      = 3'd1,
        EV_REPLACE     = 3'd2,
        EV_DELETE      = 3'd3,
        EV_ENTER_READ  = 3'd4,
        EV_ENTER_ENTRY = 3'd5,
        EV_ANIM        = 3'd6
    } event_t;

    // Number of characters behind one digit key
    function automatic logic [2:0] tap_len(input logic [3:0] digit);
        logic [2:0] n;
        begin
            unique case (digit)
                4'd7, 4'd9: n = 3'd5;
                default:    n = 3'd4;
            endcase
            return n;
        end
    endfunction

    // Character at a tap position of a digit key
    function automatic logic [6:0] tap_char(input logic [3:0] digit,
                                            input logic [2:0] pos);
        logic [34:0] row;
        logic [6:0]  c;
        begin
            unique case (digit)
                4'd0:    row = {7'h20, 7'h5F, 7'h2D, 7'h30, 7'h30};
                4'd1:    row = {7'h2E, 7'h2C, 7'h3A, 7'h31, 7'h31};
                4'd2:    row = {7'h41, 7'h42, 7'h43, 7'h32, 7'h32};
                4'd3:    row = {7'h44, 7'h45, 7'h46, 7'h33, 7'h33};
                4'd4:    row = {7'h47, 7'h48, 7'h49, 7'h34, 7'h34};
                4'd5:    row = {7'h4A, 7'h4B, 7'h4C, 7'h35, 7'h35};
                4'd6:    row = {7'h4D, 7'h4E, 7'h4F, 7'h36, 7'h36};
                4'd7:    row = {7'h50, 7'h51, 7'h52, 7'h53, 7'h37};
                4'd8:    row = {7'h54, 7'h55, 7'h56, 7'h38, 7'h38};
                4'd9:    row = {7'h57, 7'h58, 7'h59, 7'h5A, 7'h39};
                default: row = '0;
            endcase
            unique case (pos)
                3'd0:    c = row[34:28];
                3'd1:    c = row[27:21];
                3'd2:    c = row[20:14];
                3'd3:    c = row[13:7];
                3'd4:    c = row[6:0];
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage : mtk_pkg
`default_nettype wire

// ===== src/mtk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_front
// Edge detection on the key sample and classification into key commands.
// ----------------------------------------------------------------------------
module mtk_front
    import mtk_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [4:0] key_sample,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            push_cmd
);

    logic [4:0] prev_key_reg;
    logic [4:0] prev_key_next;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_cmd.kind = CMD_NONE;
        push_cmd.arg  = '0;
        if (key_sample != prev_key_reg)
        begin
            if (key_sample >= KEY_DIGIT0 && key_sample <= KEY_DIGIT9)
            begin
                push_cmd.kind = CMD_DIGIT;
                push_cmd.arg  = 4'(key_sample - KEY_DIGIT0);
            end
            else if (key_sample == KEY_STAR)
            begin
                push_cmd.kind = CMD_STAR;
            end
            else if (key_sample == KEY_HASH)
            begin
                push_cmd.kind = CMD_HASH;
            end
            else if (key_sample >= KEY_A && key_sample <= KEY_D)
            begin
                push_cmd.kind = CMD_ANIM;
                push_cmd.arg  = 4'(key_sample - KEY_A);
            end
        end
    end

    // unknown codes still count as the previous sample
    assign prev_key_next = push ? key_sample : prev_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg <= KEY_NONE;
        end
        else
        begin
            prev_key_reg <= prev_key_next;
        end
    end

endmodule : mtk_front
`default_nettype wire

// ===== src/mtk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_queue
// Short command queue between the classifier and the text engine.
// ----------------------------------------------------------------------------
module mtk_queue
    import mtk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : mtk_queue
`default_nettype wire

// ===== src/mtk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_back
// Text engine: timeout, multi-tap cycling, text store, modes and the
// registered result word.
// ----------------------------------------------------------------------------
module mtk_back
    import mtk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [15:0]       cfg_wr_data,
    input  wire logic              q_empty,
    input  wire cmd_t              q_head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             event_res,
    output logic [6:0]             char_code,
    output logic [LEN_W-1:0]       text_length,
    output logic                   pending_flag,
    output logic                   read_active,
    output logic [1:0]             anim_choice
);

    logic [6:0]        text_mem [TEXT_CAP];
    logic [6:0]        rd_data_reg;

    logic [15:0]       timeout_reg, timeout_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  ns_reg, ns_next;
    logic [3:0]        dig_reg, dig_next;
    logic [2:0]        pos_reg, pos_next;
    logic              pend_reg, pend_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic              read_reg, read_next;
    logic [6:0]        last_char_reg, last_char_next;
    logic              last_ram_reg, last_ram_next;

    logic              out_valid_reg, out_valid_next;
    event_t            ev_reg, ev_next;
    logic [6:0]        code_reg, code_next;
    logic [1:0]        anim_reg, anim_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [6:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              fire;
    logic [6:0]        last_eff;
    logic [6:0]        new_char;
    logic [2:0]        pos_inc;
    logic              ns_dec;
    logic              ns_inc;

    assign fire     = !q_empty && (!out_valid_reg || out_ready);
    assign pop      = fire;
    assign last_eff = last_ram_reg ? rd_data_reg : last_char_reg;

    assign timeout_next = cfg_wr_en ? cfg_wr_data : timeout_reg;

    always_comb
    begin
        len_next       = len_reg;
        ns_next        = ns_reg;
        dig_next       = dig_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        read_next      = read_reg;
        last_char_next = last_char_reg;
        last_ram_next  = last_ram_reg;
        ev_next        = ev_reg;
        code_next      = code_reg;
        anim_next      = anim_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(len_reg);
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = ADDR_W'(len_reg - LEN_W'(2));
        new_char       = '0;
        pos_inc        = '0;
        ns_dec         = 1'b0;
        ns_inc         = 1'b0;

        if (fire)
        begin
            out_valid_next = 1'b1;
            ev_next        = EV_NONE;
            code_next      = '0;
            anim_next      = '0;

            // timeout runs before the key acts
            if (!read_reg && pend_reg)
            begin
                if (cnt_reg <= 16'd1)
                begin
                    pend_next = 1'b0;
                    dig_next  = '0;
                    pos_next  = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg - 16'd1;
                end
            end

            unique case (q_head.kind)
                CMD_DIGIT:
                begin
                    if (!read_reg)
                    begin
                        if (pend_next && dig_next == q_head.arg && len_reg != '0)
                        begin
                            pos_inc  = pos_next + 3'd1;
                            pos_next = (pos_inc < tap_len(q_head.arg)) ? pos_inc : 3'd0;
                            new_char = tap_char(q_head.arg, pos_next);
                            ns_dec   = (last_eff != SPACE_CHAR) && (ns_reg != '0);
                            ns_inc   = (new_char != SPACE_CHAR);
                            ns_next  = ns_reg - LEN_W'(ns_dec) + LEN_W'(ns_inc);
                            mem_we         = 1'b1;
                            mem_waddr      = ADDR_W'(len_reg - LEN_W'(1));
                            mem_wdata      = new_char;
                            last_char_next = new_char;
                            last_ram_next  = 1'b0;
                            cnt_next       = timeout_reg;
                            code_next      = new_char;
                            ev_next        = EV_REPLACE;
                        end
                        else if (len_reg < LEN_W'(TEXT_CAP))
                        begin
                            new_char  = tap_char(q_head.arg, 3'd0);
                            pend_next = 1'b1;
                            dig_next  = q_head.arg;
                            pos_next  = '0;
                            cnt_next  = timeout_reg;
                            ns_inc    = (new_char != SPACE_CHAR);
                            ns_next   = ns_reg + LEN_W'(ns_inc);
                            len_next  = len_reg + LEN_W'(1);
                            mem_we         = 1'b1;
                            mem_waddr      = ADDR_W'(len_reg);
                            mem_wdata      = new_char;
                            last_char_next = new_char;
                            last_ram_next  = 1'b0;
                            code_next      = new_char;
                            ev_next        = EV_APPEND;
                        end
                    end
                end
                CMD_STAR:
                begin
                    if (!read_reg)
                    begin
                        if (len_reg != '0)
                        begin
                            len_next = len_reg - LEN_W'(1);
                            ns_dec   = (last_eff != SPACE_CHAR) && (ns_reg != '0);
                            ns_next  = ns_reg - LEN_W'(ns_dec);
                            // fetch the character that becomes the last one
                            mem_re        = (len_reg >= LEN_W'(2));
                            last_ram_next = 1'b1;
                            pend_next = 1'b0;
                            dig_next  = '0;
                            pos_next  = '0;
                            cnt_next  = '0;
                            ev_next   = EV_DELETE;
                        end
                    end
                    else
                    begin
                        read_next = 1'b0;
                        pend_next = 1'b0;
                        dig_next  = '0;
                        pos_next  = '0;
                        cnt_next  = '0;
                        ev_next   = EV_ENTER_ENTRY;
                    end
                end
                CMD_HASH:
                begin
                    if (!read_reg && ns_reg != '0)
                    begin
                        read_next = 1'b1;
                        pend_next = 1'b0;
                        dig_next  = '0;
                        pos_next  = '0;
                        cnt_next  = '0;
                        ev_next   = EV_ENTER_READ;
                    end
                end
                CMD_ANIM:
                begin
                    if (read_reg)
                    begin
                        anim_next = q_head.arg[1:0];
                        ev_next   = EV_ANIM;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // text store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= text_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        last_char_reg <= last_char_next;
        code_reg      <= code_next;
        anim_reg      <= anim_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= WR_TIMEOUT_RESET;
            len_reg       <= '0;
            ns_reg        <= '0;
            dig_reg       <= '0;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            read_reg      <= 1'b0;
            last_ram_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ev_reg        <= EV_NONE;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            len_reg       <= len_next;
            ns_reg        <= ns_next;
            dig_reg       <= dig_next;
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            read_reg      <= read_next;
            last_ram_reg  <= last_ram_next;
            out_valid_reg <= out_valid_next;
            ev_reg        <= ev_next;
        end
    end

    // result word holds the state after its tick
    logic [LEN_W-1:0] len_out_reg;
    logic             pend_out_reg;
    logic             read_out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            len_out_reg  <= len_next;
            pend_out_reg <= pend_next;
            read_out_reg <= read_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = ev_reg;
    assign char_code    = code_reg;
    assign text_length  = len_out_reg;
    assign pending_flag = pend_out_reg;
    assign read_active  = read_out_reg;
    assign anim_choice  = anim_reg;

endmodule : mtk_back
`default_nettype wire

// ===== src/multitap_keypad_text_entry_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry_top
// Multi-tap keypad text entry: one word per keypad polling tick in, one
// result word per tick out.
// ----------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  -------   ---------------------    -----------------------------------------
//  in        in_valid / in_ready      key_sample
//  out       out_valid / out_ready    event_res, char_code, text_length,
//                                     pending_flag, read_active, anim_choice
//  cfg       cfg_wr_en (no stall)     cfg_wr_data = write timeout in ticks
//
//  One word per clock sustained while out_ready stays high; an accepted word
//  passes a queue slot, then the text engine register, before its result is valid.
//  The text store has one write and one registered read port; a delete
//  prefetches the new last character, so back-to-back deletes do not stall.
//  Reset (rst_n low, async) clears mode, counts, pending state and timeout
//  (back to 30000); the text store itself is not cleared.
//  A stalled output holds its word; the two-deep queue keeps taking words
//  until it is full, then in_ready drops.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry_top
    import mtk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [15:0]       cfg_wr_data,
    // key tick input
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [4:0]        key_sample,
    // result output
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             event_res,
    output logic [6:0]             char_code,
    output logic [LEN_W-1:0]       text_length,
    output logic                   pending_flag,
    output logic                   read_active,
    output logic [1:0]             anim_choice
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_push_cmd;
    cmd_t q_head;

    // Front: key change detect and classify
    mtk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_sample (key_sample),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (q_push_cmd)
    );

    // Decoupling queue
    mtk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back: text engine and result register
    mtk_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .char_code    (char_code),
        .text_length  (text_length),
        .pending_flag (pending_flag),
        .read_active  (read_active),
        .anim_choice  (anim_choice)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // nothing can be pending while in read mode
    a_no_pending_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pending_flag && read_active))
        else $error("pending character reported in read mode");

    // text never grows past capacity
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_length <= LEN_W'(TEXT_CAP)))
        else $error("text length above capacity");

    // an append or replace always leaves a pending character
    a_tap_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_APPEND || event_res == EV_REPLACE))
            |-> pending_flag)
        else $error("tap event without pending character");

    // animation choices only come from read mode
    a_anim_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_ANIM) |-> read_active)
        else $error("animation event outside read mode");

endmodule : multitap_keypad_text_entry_top
`default_nettype wire
